// ===== rtl/rsi_pkg.sv =====
package rsi_pkg;

    // Default coordinate format: Q16.16 in 32 bits.
    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;

    // Configuration register index width and register map.
    localparam int CFG_INDEX_W = 3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_CENTER_X = 3'd0,
        REG_CENTER_Y = 3'd1,
        REG_CENTER_Z = 3'd2,
        REG_RADIUS   = 3'd3
    } cfg_reg_t;

endpackage

// ===== rtl/rsi_front.sv =====
module rsi_front
    import rsi_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF,
    localparam int CW   = COORD_WIDTH,
    localparam int DW   = FRAC_BITS + 2,
    localparam int RW   = COORD_WIDTH - 1,
    localparam int LW   = COORD_WIDTH + 1,
    localparam int DOTW = LW + DW + 2,
    localparam int SW   = DOTW - FRAC_BITS,
    localparam int D2W  = 2 * LW + 2,
    localparam int MW   = 2 * SW + 1
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic signed [CW-1:0] origin_x,
    input  logic signed [CW-1:0] origin_y,
    input  logic signed [CW-1:0] origin_z,
    input  logic signed [DW-1:0] dir_x,
    input  logic signed [DW-1:0] dir_y,
    input  logic signed [DW-1:0] dir_z,
    input  logic signed [CW-1:0] center_x,
    input  logic signed [CW-1:0] center_y,
    input  logic signed [CW-1:0] center_z,
    input  logic        [RW-1:0] radius,
    output logic                 vld,
    output logic        [2*RW-1:0] q2,
    output logic signed [SW-1:0] s,
    output logic                 outside,
    output logic                 miss,
    output logic signed [CW-1:0] o_out [3],
    output logic signed [DW-1:0] d_out [3]
);

    logic signed [CW-1:0] o_in [3];
    logic signed [DW-1:0] d_in [3];
    logic signed [CW-1:0] c_in [3];

    assign o_in[0] = origin_x;
    assign o_in[1] = origin_y;
    assign o_in[2] = origin_z;
    assign d_in[0] = dir_x;
    assign d_in[1] = dir_y;
    assign d_in[2] = dir_z;
    assign c_in[0] = center_x;
    assign c_in[1] = center_y;
    assign c_in[2] = center_z;

    // Ray origin and direction ride along with every stage.
    logic signed [CW-1:0] o1_reg [3], o2_reg [3], o3_reg [3], o4_reg [3], o5_reg [3];
    logic signed [DW-1:0] d1_reg [3], d2d_reg [3], d3_reg [3], d4_reg [3], d5_reg [3];
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;

    // Stage 1: offset from the origin to the center.
    logic signed [LW-1:0] l_next [3];
    logic signed [LW-1:0] l_reg  [3];

    // Stage 2: products of the offset with the direction and with itself.
    logic signed [LW+DW-1:0] ld_next [3];
    logic signed [LW+DW-1:0] ld_reg  [3];
    logic signed [2*LW-1:0]  ll_next [3];
    logic signed [2*LW-1:0]  ll_reg  [3];
    logic        [2*RW-1:0]  r2_next, r2a_reg;

    // Stage 3: sums, projection and the outside test.
    logic signed [DOTW-1:0] dot_sum;
    logic signed [D2W-1:0]  d2_next, d2_reg;
    logic signed [SW-1:0]   s_next, s3_reg;
    logic                   out_next, out3_reg;
    logic        [2*RW-1:0] r2b_reg;

    // Stage 4: square of the projection.
    logic signed [2*SW-1:0] ss_next, ss_reg;
    logic signed [D2W-1:0]  d2b_reg;
    logic        [2*RW-1:0] r2c_reg;
    logic signed [SW-1:0]   s4_reg;
    logic                   out4_reg, miss4_reg;

    // Stage 5: squared line distance and the radicand.
    logic signed [MW-1:0]   m2_raw, m2_clip, r2_ext;
    logic        [2*RW-1:0] q2_next, q2_reg;
    logic                   miss_next, miss5_reg, out5_reg;
    logic signed [SW-1:0]   s5_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            l_next[i]  = LW'(c_in[i]) - LW'(o_in[i]);
            ld_next[i] = l_reg[i] * d1_reg[i];
            ll_next[i] = l_reg[i] * l_reg[i];
        end
        r2_next = (2*RW)'(radius) * (2*RW)'(radius);
        dot_sum = DOTW'(ld_reg[0]) + DOTW'(ld_reg[1]) + DOTW'(ld_reg[2]);
        d2_next = D2W'(ll_reg[0]) + D2W'(ll_reg[1]) + D2W'(ll_reg[2]);
        s_next  = dot_sum[DOTW-1:FRAC_BITS];
        out_next = d2_next > $signed({{(D2W-2*RW){1'b0}}, r2a_reg});
        ss_next = s3_reg * s3_reg;
        m2_raw  = MW'(d2b_reg) - MW'(ss_reg);
        m2_clip = m2_raw[MW-1] ? '0 : m2_raw;
        r2_ext  = $signed({{(MW-2*RW){1'b0}}, r2c_reg});
        miss_next = miss4_reg || (m2_clip > r2_ext);
        q2_next = r2c_reg - m2_clip[2*RW-1:0];
    end

    // Valid bits of the five stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    // Stage payloads.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                o1_reg[i]  <= o_in[i];
                d1_reg[i]  <= d_in[i];
                l_reg[i]   <= l_next[i];
                o2_reg[i]  <= o1_reg[i];
                d2d_reg[i] <= d1_reg[i];
                ld_reg[i]  <= ld_next[i];
                ll_reg[i]  <= ll_next[i];
                o3_reg[i]  <= o2_reg[i];
                d3_reg[i]  <= d2d_reg[i];
                o4_reg[i]  <= o3_reg[i];
                d4_reg[i]  <= d3_reg[i];
                o5_reg[i]  <= o4_reg[i];
                d5_reg[i]  <= d4_reg[i];
            end
            r2a_reg   <= r2_next;
            d2_reg    <= d2_next;
            s3_reg    <= s_next;
            out3_reg  <= out_next;
            r2b_reg   <= r2a_reg;
            ss_reg    <= ss_next;
            d2b_reg   <= d2_reg;
            r2c_reg   <= r2b_reg;
            s4_reg    <= s3_reg;
            out4_reg  <= out3_reg;
            miss4_reg <= s3_reg[SW-1] && out3_reg;
            q2_reg    <= q2_next;
            miss5_reg <= miss_next;
            out5_reg  <= out4_reg;
            s5_reg    <= s4_reg;
        end
    end

    assign vld     = v5_reg;
    assign q2      = q2_reg;
    assign s       = s5_reg;
    assign outside = out5_reg;
    assign miss    = miss5_reg;
    assign o_out   = o5_reg;
    assign d_out   = d5_reg;

endmodule

// ===== rtl/rsi_sqrt.sv =====
module rsi_sqrt
    import rsi_pkg::*;
#(
    parameter int N      = COORD_WIDTH_DEF - 1,
    parameter int SIDE_W = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [2*N-1:0]    rad,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_valid,
    output logic [N-1:0]      root,
    output logic [SIDE_W-1:0] side_out
);

    // One root bit per stage, restoring method.
    logic [2*N-1:0]    rad_src  [N];
    logic [N:0]        rem_src  [N];
    logic [N-1:0]      root_src [N];
    logic              vld_src  [N];
    logic [SIDE_W-1:0] side_src [N];

    logic [2*N-1:0]    rad_reg  [N];
    logic [N:0]        rem_reg  [N];
    logic [N-1:0]      root_reg [N];
    logic              vld_reg  [N];
    logic [SIDE_W-1:0] side_reg [N];

    assign rad_src[0]  = rad;
    assign rem_src[0]  = '0;
    assign root_src[0] = '0;
    assign vld_src[0]  = in_valid;
    assign side_src[0] = side_in;

    for (genvar k = 0; k < N; k++)
    begin : g_stage
        logic [N+2:0] rem_sh;
        logic [N+2:0] trial;
        logic         take;
        logic [N:0]   rem_next;
        logic [N-1:0] root_next;

        if (k > 0)
        begin : g_link
            assign rad_src[k]  = rad_reg[k-1];
            assign rem_src[k]  = rem_reg[k-1];
            assign root_src[k] = root_reg[k-1];
            assign vld_src[k]  = vld_reg[k-1];
            assign side_src[k] = side_reg[k-1];
        end

        assign rem_sh    = {rem_src[k], rad_src[k][2*N-1:2*N-2]};
        assign trial     = {1'b0, root_src[k], 2'b01};
        assign take      = rem_sh >= trial;
        assign rem_next  = take ? (N+1)'(rem_sh - trial) : rem_sh[N:0];
        assign root_next = {root_src[k][N-2:0], take};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= vld_src[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rad_reg[k]  <= {rad_src[k][2*N-3:0], 2'b00};
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                side_reg[k] <= side_src[k];
            end
        end
    end

    assign out_valid = vld_reg[N-1];
    assign root      = root_reg[N-1];
    assign side_out  = side_reg[N-1];

endmodule

// ===== rtl/rsi_back.sv =====
module rsi_back
    import rsi_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF,
    localparam int CW  = COORD_WIDTH,
    localparam int DW  = FRAC_BITS + 2,
    localparam int RW  = COORD_WIDTH - 1,
    localparam int SW  = COORD_WIDTH + 5,
    localparam int TW  = SW + 1,
    localparam int PRW = TW + DW,
    localparam int PW  = PRW - FRAC_BITS + 1
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic        [RW-1:0] q,
    input  logic signed [SW-1:0] s,
    input  logic                 outside,
    input  logic                 miss,
    input  logic signed [CW-1:0] o_in [3],
    input  logic signed [DW-1:0] d_in [3],
    output logic                 out_valid,
    output logic                 hit,
    output logic signed [CW-1:0] point_x,
    output logic signed [CW-1:0] point_y,
    output logic signed [CW-1:0] point_z,
    output logic        [CW-1:0] distance
);

    localparam logic signed [PW-1:0] PMAX = PW'({1'b0, {(CW-1){1'b1}}});
    localparam logic signed [PW-1:0] PMIN = -PMAX - PW'(1);

    logic vt_reg, vp_reg, vf_reg;

    // Stage T: ray parameter, clamped at zero.
    logic signed [TW-1:0] t_raw, t_next, t_reg, tp_reg;
    logic                 misst_reg, missp_reg;
    logic signed [CW-1:0] ot_reg [3], op_reg [3];
    logic signed [DW-1:0] dt_reg [3];

    // Stage P: step along the direction.
    logic signed [PRW-1:0] prod_next [3];
    logic signed [PRW-1:0] prod_reg  [3];

    // Stage F: hit point and saturation into the output register.
    logic signed [PW-1:0] p_sum [3];
    logic signed [CW-1:0] p_sat [3];
    logic        [CW-1:0] dist_sat;
    logic                 hit_reg;
    logic signed [CW-1:0] px_reg, py_reg, pz_reg;
    logic        [CW-1:0] dist_reg;

    always_comb
    begin
        t_raw  = outside ? (TW'(s) - TW'(q)) : (TW'(s) + TW'(q));
        t_next = t_raw[TW-1] ? '0 : t_raw;
        for (int i = 0; i < 3; i++)
        begin
            prod_next[i] = PRW'(t_reg) * PRW'(dt_reg[i]);
            p_sum[i] = PW'($signed(prod_reg[i][PRW-1:FRAC_BITS])) + PW'(op_reg[i]);
            if (p_sum[i] > PMAX)
            begin
                p_sat[i] = PMAX[CW-1:0];
            end
            else if (p_sum[i] < PMIN)
            begin
                p_sat[i] = PMIN[CW-1:0];
            end
            else
            begin
                p_sat[i] = p_sum[i][CW-1:0];
            end
        end
        dist_sat = (tp_reg[TW-1:CW] != '0) ? '1 : tp_reg[CW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vt_reg <= 1'b0;
            vp_reg <= 1'b0;
            vf_reg <= 1'b0;
        end
        else if (en)
        begin
            vt_reg <= in_valid;
            vp_reg <= vt_reg;
            vf_reg <= vp_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_reg     <= t_next;
            misst_reg <= miss;
            tp_reg    <= t_reg;
            missp_reg <= misst_reg;
            for (int i = 0; i < 3; i++)
            begin
                ot_reg[i]   <= o_in[i];
                dt_reg[i]   <= d_in[i];
                op_reg[i]   <= ot_reg[i];
                prod_reg[i] <= prod_next[i];
            end
            // A miss clears the whole result.
            hit_reg  <= !missp_reg;
            px_reg   <= missp_reg ? '0 : p_sat[0];
            py_reg   <= missp_reg ? '0 : p_sat[1];
            pz_reg   <= missp_reg ? '0 : p_sat[2];
            dist_reg <= missp_reg ? '0 : dist_sat;
        end
    end

    assign out_valid = vf_reg;
    assign hit       = hit_reg;
    assign point_x   = px_reg;
    assign point_y   = py_reg;
    assign point_z   = pz_reg;
    assign distance  = dist_reg;

endmodule

// ===== rtl/ray_sphere_intersect.sv =====
// Channel   Direction  Handshake            Beat
// input     in         in_valid/in_stall    origin_x/y/z, dir_x/y/z
// output    out        out_valid/out_stall  hit, point_x/y/z, distance
// config    in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One ray is accepted per cycle unless the output stalls; each result passes through
// the five front stages, the square root that resolves one bit per stage, and three
// back stages.
// Reset clears all valid bits and loads center 0 and radius 1.0; config is always ready.
// An output stall freezes the whole pipeline; bubbles still advance while the output is empty.
module ray_sphere_intersect
    import rsi_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic signed [COORD_WIDTH-1:0]  origin_x,
    input  logic signed [COORD_WIDTH-1:0]  origin_y,
    input  logic signed [COORD_WIDTH-1:0]  origin_z,
    input  logic signed [FRAC_BITS+1:0]    dir_x,
    input  logic signed [FRAC_BITS+1:0]    dir_y,
    input  logic signed [FRAC_BITS+1:0]    dir_z,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           hit,
    output logic signed [COORD_WIDTH-1:0]  point_x,
    output logic signed [COORD_WIDTH-1:0]  point_y,
    output logic signed [COORD_WIDTH-1:0]  point_z,
    output logic        [COORD_WIDTH-1:0]  distance,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic        [CFG_INDEX_W-1:0]  cfg_index,
    input  logic        [COORD_WIDTH-1:0]  cfg_data
);

    localparam int CW     = COORD_WIDTH;
    localparam int DW     = FRAC_BITS + 2;
    localparam int RW     = COORD_WIDTH - 1;
    localparam int SW     = COORD_WIDTH + 5;
    localparam int SIDE_W = SW + 2 + 3 * CW + 3 * DW;

    logic signed [CW-1:0] cx_reg, cy_reg, cz_reg;
    logic        [RW-1:0] rad_reg;
    logic                 en;

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg  <= '0;
            cy_reg  <= '0;
            cz_reg  <= '0;
            rad_reg <= RW'(1) << FRAC_BITS;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_CENTER_X: cx_reg  <= cfg_data;
                REG_CENTER_Y: cy_reg  <= cfg_data;
                REG_CENTER_Z: cz_reg  <= cfg_data;
                REG_RADIUS:   rad_reg <= cfg_data[RW-1:0];
                default:      ;
            endcase
        end
    end

    // The pipeline moves unless a finished beat waits at the output.
    assign en       = !out_valid || !out_stall;
    assign in_stall = !en;

    logic                 f_vld, f_outside, f_miss;
    logic [2*RW-1:0]      f_q2;
    logic signed [SW-1:0] f_s;
    logic signed [CW-1:0] f_o [3];
    logic signed [DW-1:0] f_d [3];

    rsi_front #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (in_valid),
        .origin_x (origin_x),
        .origin_y (origin_y),
        .origin_z (origin_z),
        .dir_x    (dir_x),
        .dir_y    (dir_y),
        .dir_z    (dir_z),
        .center_x (cx_reg),
        .center_y (cy_reg),
        .center_z (cz_reg),
        .radius   (rad_reg),
        .vld      (f_vld),
        .q2       (f_q2),
        .s        (f_s),
        .outside  (f_outside),
        .miss     (f_miss),
        .o_out    (f_o),
        .d_out    (f_d)
    );

    // Side data rides through the square root stages.
    logic [SIDE_W-1:0]    side_in, side_out;
    logic                 r_vld;
    logic [RW-1:0]        r_q;
    logic signed [SW-1:0] r_s;
    logic                 r_outside, r_miss;
    logic signed [CW-1:0] r_o [3];
    logic signed [DW-1:0] r_d [3];

    assign side_in = {f_s, f_outside, f_miss, f_o[0], f_o[1], f_o[2],
                      f_d[0], f_d[1], f_d[2]};
    assign {r_s, r_outside, r_miss, r_o[0], r_o[1], r_o[2],
            r_d[0], r_d[1], r_d[2]} = side_out;

    rsi_sqrt #(.N(RW), .SIDE_W(SIDE_W)) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (f_vld),
        .rad       (f_q2),
        .side_in   (side_in),
        .out_valid (r_vld),
        .root      (r_q),
        .side_out  (side_out)
    );

    rsi_back #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (r_vld),
        .q         (r_q),
        .s         (r_s),
        .outside   (r_outside),
        .miss      (r_miss),
        .o_in      (r_o),
        .d_in      (r_d),
        .out_valid (out_valid),
        .hit       (hit),
        .point_x   (point_x),
        .point_y   (point_y),
        .point_z   (point_z),
        .distance  (distance)
    );

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
    import rsi_pkg::*;

    localparam int CW = 32;
    localparam int FB = 16;
    localparam int LATENCY = CW + 7;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic                 hit;
        logic signed [CW-1:0] px;
        logic signed [CW-1:0] py;
        logic signed [CW-1:0] pz;
        logic        [CW-1:0] t_dist;
    } hit_beat_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic signed [CW-1:0] origin_x, origin_y, origin_z;
    logic signed [FB+1:0] dir_x, dir_y, dir_z;
    logic out_valid;
    logic out_stall;
    logic hit;
    logic signed [CW-1:0] point_x, point_y, point_z;
    logic [CW-1:0] distance;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CW-1:0] cfg_data;

    // Model copy of the sphere registers.
    logic signed [CW-1:0] sph_cx, sph_cy, sph_cz;
    logic [CW-2:0] sph_r;

    hit_beat_t expected_hits[$];
    int errors;
    int rays_sent;
    int hits_seen;
    int beats_checked;
    int idle_cycles;

    ray_sphere_intersect dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .origin_x(origin_x), .origin_y(origin_y), .origin_z(origin_z),
        .dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z),
        .out_valid(out_valid), .out_stall(out_stall),
        .hit(hit), .point_x(point_x), .point_y(point_y), .point_z(point_z),
        .distance(distance),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Integer square root, rounded down, of a nonnegative 128-bit value.
    function automatic logic [63:0] isqrt128(logic [127:0] v);
        logic [63:0] root;
        logic [63:0] cand;
        root = '0;
        for (int b = 63; b >= 0; b--)
        begin
            cand = root | (64'd1 << b);
            if ({64'd0, cand} * {64'd0, cand} <= v)
                root = cand;
        end
        return root;
    endfunction

    // Expected result of one ray against the current sphere.
    function automatic hit_beat_t trace_ray(logic signed [CW-1:0] ox, logic signed [CW-1:0] oy,
                                            logic signed [CW-1:0] oz, logic signed [FB+1:0] dx,
                                            logic signed [FB+1:0] dy, logic signed [FB+1:0] dz);
        hit_beat_t res;
        logic signed [127:0] o[3], d[3], l[3];
        logic signed [127:0] dotp, d2, s, r2, m2, q2, q, t, p;
        logic signed [127:0] pmax, pmin;
        bit outside;
        res = '0;
        o[0] = ox; o[1] = oy; o[2] = oz;
        d[0] = dx; d[1] = dy; d[2] = dz;
        l[0] = 128'(sph_cx) - o[0];
        l[1] = 128'(sph_cy) - o[1];
        l[2] = 128'(sph_cz) - o[2];
        dotp = 0;
        d2 = 0;
        for (int i = 0; i < 3; i++)
        begin
            dotp += l[i] * d[i];
            d2 += l[i] * l[i];
        end
        s = dotp >>> FB;
        r2 = $signed({97'd0, sph_r}) * $signed({97'd0, sph_r});
        outside = d2 > r2;
        if (s < 0 && outside)
            return res;
        m2 = d2 - s * s;
        if (m2 < 0)
            m2 = 0;
        if (m2 > r2)
            return res;
        q2 = r2 - m2;
        q = $signed({64'd0, isqrt128(q2)});
        t = outside ? s - q : s + q;
        if (t < 0)
            t = 0;
        pmax = (128'sd1 <<< (CW - 1)) - 1;
        pmin = -pmax - 1;
        res.hit = 1'b1;
        for (int i = 0; i < 3; i++)
        begin
            p = ((t * d[i]) >>> FB) + o[i];
            if (p > pmax) p = pmax;
            if (p < pmin) p = pmin;
            if (i == 0) res.px = p[CW-1:0];
            else if (i == 1) res.py = p[CW-1:0];
            else res.pz = p[CW-1:0];
        end
        res.t_dist = (t > ((128'sd1 <<< CW) - 1)) ? '1 : t[CW-1:0];
        return res;
    endfunction

    function automatic int gap_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 45) return 0;
        if (pick < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Send one ray beat and queue the expected result.
    task automatic send_ray(logic signed [CW-1:0] ox, logic signed [CW-1:0] oy,
                            logic signed [CW-1:0] oz, logic signed [FB+1:0] dx,
                            logic signed [FB+1:0] dy, logic signed [FB+1:0] dz,
                            bit allow_gap = 1'b1);
        int gap;
        gap = allow_gap ? gap_len() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        origin_x <= ox; origin_y <= oy; origin_z <= oz;
        dir_x <= dx; dir_y <= dy; dir_z <= dz;
        expected_hits.push_back(trace_ray(ox, oy, oz, dx, dy, dz));
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        rays_sent++;
    endtask

    task automatic end_burst();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Drain the pipeline so a register write sees an idle block.
    task automatic wait_drained();
        end_burst();
        while (expected_hits.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    // One register write; the caller drops cfg_valid after the last one.
    task automatic write_reg(cfg_reg_t idx, logic [CW-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_CENTER_X: sph_cx = value;
            REG_CENTER_Y: sph_cy = value;
            REG_CENTER_Z: sph_cz = value;
            REG_RADIUS:   sph_r = value[CW-2:0];
            default: ;
        endcase
    endtask

    task automatic set_sphere(logic [CW-1:0] cx, logic [CW-1:0] cy, logic [CW-1:0] cz,
                              logic [CW-1:0] r);
        wait_drained();
        write_reg(REG_CENTER_X, cx);
        write_reg(REG_CENTER_Y, cy);
        write_reg(REG_CENTER_Z, cz);
        write_reg(REG_RADIUS, r);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [FB+1:0] rand_dir();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) return 18'sd65536;
        if (pick == 1) return -18'sd65536;
        if (pick == 2) return 18'(int'($urandom));
        return 18'($signed($urandom_range(0, 131072)) - 65536);
    endfunction

    function automatic logic signed [CW-1:0] rand_coord(int span);
        if ($urandom_range(0, 7) == 0)
            return $urandom;
        return $signed($urandom_range(0, 2 * span)) - span;
    endfunction

    // Corner cases of the geometry, starting with the reset-value sphere.
    task automatic test_directed();
        set_sphere(0, 0, 0, 32'h0001_0000);
        // Outside, aimed at the center: hit.
        send_ray(-32'sh0004_0000, 0, 0, 18'sd65536, 0, 0);
        // Outside, pointing away: miss behind.
        send_ray(-32'sh0004_0000, 0, 0, -18'sd65536, 0, 0);
        // Outside, passing beside: miss on distance.
        send_ray(-32'sh0004_0000, 32'sh0002_0000, 0, 18'sd65536, 0, 0);
        // Tangent ray.
        send_ray(-32'sh0004_0000, 32'sh0001_0000, 0, 18'sd65536, 0, 0);
        // Origin inside and at the center.
        send_ray(0, 0, 0, 0, 18'sd65536, 0);
        send_ray(0, 0, 32'sh0000_8000, 0, 0, -18'sd65536);
        // On the sphere surface.
        send_ray(32'sh0001_0000, 0, 0, 18'sd65536, 0, 0);
        // Zero direction and non-unit directions.
        send_ray(-32'sh0004_0000, 0, 0, 0, 0, 0);
        send_ray(-32'sh0004_0000, 0, 0, 18'sh1ffff, 18'sh1ffff, 18'sh1ffff);
        send_ray(-32'sh0004_0000, 0, 0, 18'sh20000, 18'sh20000, 18'sh20000);
        // Extreme origins.
        send_ray(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, -18'sd65536, 0, 0);
        send_ray(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 18'sd65536, 0, 0);
        send_ray(32'sh8000_0000, 0, 0, 18'sd65536, 0, 0);
        // Huge sphere at an extreme center: saturation of point and distance.
        set_sphere(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        send_ray(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 18'sd65536, 18'sd65536,
                 18'sd65536);
        send_ray(32'sh8000_0000, 0, 0, 18'sd65536, 0, 0);
        send_ray(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 18'sd65536, 0, 0);
        set_sphere(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
        send_ray(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, -18'sd65536, -18'sd65536,
                 -18'sd65536);
        send_ray(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 18'sd65536, 0, 0);
        // Zero radius.
        set_sphere(0, 0, 0, 0);
        send_ray(-32'sh0001_0000, 0, 0, 18'sd65536, 0, 0);
        send_ray(0, 0, 0, 18'sd65536, 0, 0);
        // Radius register top bit is not stored.
        set_sphere(0, 0, 0, 32'h8001_0000);
        send_ray(-32'sh0004_0000, 0, 0, 18'sd65536, 0, 0);
    endtask

    // Random rays near a random sphere, plus full-range noise.
    task automatic test_random_phase(int count, int span, int rmax);
        logic signed [CW-1:0] ox, oy, oz;
        set_sphere(rand_coord(span), rand_coord(span), rand_coord(span),
                   $urandom_range(0, rmax));
        for (int k = 0; k < count; k++)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                send_ray($urandom, $urandom, $urandom, 18'($urandom), 18'($urandom),
                         18'($urandom));
            end
            else
            begin
                ox = sph_cx + rand_coord(span / 2);
                oy = sph_cy + rand_coord(span / 2);
                oz = sph_cz + rand_coord(span / 2);
                send_ray(ox, oy, oz, rand_dir(), rand_dir(), rand_dir());
            end
        end
    endtask

    // Back-to-back rays with the sender paused once until all results are in.
    task automatic test_burst_and_pause();
        for (int k = 0; k < 60; k++)
            send_ray(rand_coord(32'h0008_0000), rand_coord(32'h0008_0000),
                     rand_coord(32'h0008_0000), rand_dir(), rand_dir(), rand_dir(), 1'b0);
        end_burst();
        while (expected_hits.size() != 0)
            @(posedge clk);
        for (int k = 0; k < 40; k++)
            send_ray(rand_coord(32'h0008_0000), rand_coord(32'h0008_0000),
                     rand_coord(32'h0008_0000), rand_dir(), rand_dir(), rand_dir(), 1'b0);
    endtask

    // Receiver stall: random, with a few long holds and some free-running stretches.
    initial
    begin
        int hold;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b0;
                repeat ($urandom_range(50, 200)) @(posedge clk);
            end
            hold = gap_len();
            out_stall <= (hold != 0);
            repeat (hold == 0 ? 1 : hold) @(posedge clk);
            out_stall <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    end

    // Result checker: compare each accepted beat with the oldest expectation.
    initial
    begin
        hit_beat_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                beats_checked++;
                if (expected_hits.size() == 0)
                begin
                    $display("%0t: unexpected result beat hit=%0b", $time, hit);
                    errors++;
                end
                else
                begin
                    want = expected_hits.pop_front();
                    if (hit) hits_seen++;
                    if (hit !== want.hit)
                    begin
                        $display("%0t: hit expected %0b actual %0b", $time, want.hit, hit);
                        errors++;
                    end
                    if (point_x !== want.px)
                    begin
                        $display("%0t: point_x expected %0d actual %0d", $time, want.px,
                                 point_x);
                        errors++;
                    end
                    if (point_y !== want.py)
                    begin
                        $display("%0t: point_y expected %0d actual %0d", $time, want.py,
                                 point_y);
                        errors++;
                    end
                    if (point_z !== want.pz)
                    begin
                        $display("%0t: point_z expected %0d actual %0d", $time, want.pz,
                                 point_z);
                        errors++;
                    end
                    if (distance !== want.t_dist)
                    begin
                        $display("%0t: distance expected %0d actual %0d", $time, want.t_dist,
                                 distance);
                        errors++;
                    end
                end
            end
        end
    end

    // Watchdog: count cycles with no beat accepted on any channel.
    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: watchdog expired, %0d results outstanding", $time,
                         expected_hits.size());
                $display("status: fail");
                $finish;
            end
        end
    end

    initial
    begin
        errors = 0;
        rays_sent = 0;
        hits_seen = 0;
        beats_checked = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        origin_x = '0; origin_y = '0; origin_z = '0;
        dir_x = '0; dir_y = '0; dir_z = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_CENTER_X;
        cfg_data = '0;
        sph_cx = '0; sph_cy = '0; sph_cz = '0;
        sph_r = 31'h0001_0000;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset-value sphere before any register write.
        send_ray(-32'sh0002_0000, 0, 0, 18'sd65536, 0, 0);
        test_directed();
        test_burst_and_pause();
        test_random_phase(170, 32'h0010_0000, 32'h0008_0000);
        test_random_phase(170, 32'h0100_0000, 32'h0080_0000);
        test_random_phase(140, 32'h0000_4000, 32'h0000_4000);
        test_random_phase(140, 32'h4000_0000, 32'h7fff_ffff);
        wait_drained();

        $display("Sent %0d rays over several sphere settings, %0d results checked, %0d hits.",
                 rays_sent, beats_checked, hits_seen);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== ray_sphere_intersect.f =====
rtl/rsi_pkg.sv
rtl/rsi_front.sv
rtl/rsi_sqrt.sv
rtl/rsi_back.sv
rtl/ray_sphere_intersect.sv
tb/tb_top.sv
